// File: rtl/pip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg: shared definitions for the point-in-polygon test
// Field widths, default sizes and the command codes of an input transfer.
// ----------------------------------------------------------------------------
package pip_pkg;

  // fixed widths of the channel fields
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned CNT_W   = 5;

  // defaults for the top-level parameters
  localparam int unsigned MAX_VERTICES_DEF = 16;
  localparam int unsigned COORD_WIDTH_DEF  = 16;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_TEST  = 1'b1
  } cmd_e;

endpackage

// File: rtl/pip_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pip_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/point_in_polygon_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test: crossing-number point-in-polygon test
// Vertex store plus a sequencer that walks the polygon edges through one
// shared signed multiplier.
// ----------------------------------------------------------------------------
// A write transfer (cmd 0) stores one vertex and the block is ready again
// at once. A test transfer (cmd 1) walks the first vertex_count stored
// vertices (saturated to MAX_VERTICES) as a closed polygon and returns one
// inside bit. With 3 or more vertices, each vertex is read once on the
// single read port of the vertex RAM, the last one also up front as the
// start of the first edge, and each edge that straddles the point's y
// needs two products from the one multiplier. A count below 3 answers
// outside. Input stall stays high while a test runs; a finished result
// waits in the output register and may hold the next test at its last
// cycle.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
  parameter int unsigned MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic        [pip_pkg::IDX_W-1:0]   vertex_index_i,
  input  logic signed [pip_pkg::COORD_W-1:0] x_i,
  input  logic signed [pip_pkg::COORD_W-1:0] y_i,
  input  logic        [pip_pkg::CNT_W-1:0]   vertex_count_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              inside_res_o
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned NW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOADJ,
    S_FETCH,
    S_MULA,
    S_MULB,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  logic          out_valid_q, out_valid_d;
  logic          inside_q, inside_d;
  logic          parity_q, parity_d;
  logic          pend_q, pend_d;
  logic [NW-1:0] n_q, n_d;
  logic [NW-1:0] i_q, i_d;

  logic signed [CW-1:0] px_q, px_d;
  logic signed [CW-1:0] py_q, py_d;
  logic signed [CW-1:0] prev_x_q, prev_y_q;
  logic signed [DW-1:0] dxp_q, dxj_q, dy_q, dpy_q;
  logic signed [PW-1:0] p1_q, p2_q;
  logic                 dy_pos_q;

  logic                 accept;
  logic                 is_test;
  logic [NW-1:0]        n_sat;
  logic                 last;
  logic                 less;

  logic                 ram_we;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [2*CW-1:0]      ram_wdata;
  logic [2*CW-1:0]      ram_rdata;
  logic signed [CW-1:0] rd_x, rd_y;
  logic                 straddle;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;

  assign in_stall_o   = (state_q != S_IDLE);
  assign accept       = in_valid_i & ~in_stall_o;
  assign is_test      = (cmd_i == pip_pkg::CMD_TEST);
  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

  assign n_sat = (int'(vertex_count_i) > MAX_VERTICES) ? NW'(MAX_VERTICES)
                                                       : NW'(vertex_count_i);
  assign last  = (i_q == n_q - NW'(1));

  // vertex store: x in the upper half, y in the lower half of a row
  assign ram_we    = accept & ~is_test & (int'(vertex_index_i) < MAX_VERTICES);
  assign ram_wdata = {CW'($unsigned(x_i)), CW'($unsigned(y_i))};
  assign rd_x      = $signed(ram_rdata[2*CW-1:CW]);
  assign rd_y      = $signed(ram_rdata[CW-1:0]);

  pip_ram #(
    .WIDTH (2 * CW),
    .DEPTH (MAX_VERTICES)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (AW'(vertex_index_i)),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  // edge i (from read data) against edge end j (held in prev)
  assign straddle = (rd_y > py_q) != (prev_y_q > py_q);

  // shared multiplier: lhs in MULA, rhs in MULB, sides swapped for dy < 0
  always_comb begin
    if ((state_q == S_MULA) == dy_pos_q) begin
      mul_a = dxp_q;
      mul_b = dy_q;
    end else begin
      mul_a = dxj_q;
      mul_b = dpy_q;
    end
  end

  assign prod = PW'(mul_a) * PW'(mul_b);
  assign less = (p1_q < p2_q);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    inside_d    = inside_q;
    n_d         = n_q;
    i_d         = i_q;
    px_d        = px_q;
    py_d        = py_q;
    ram_re      = 1'b0;
    ram_raddr   = AW'(i_q + NW'(1));
    // fold a finished compare into the parity
    parity_d    = parity_q ^ (pend_q & less);
    pend_d      = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept && is_test) begin
          px_d     = CW'($unsigned(x_i));
          py_d     = CW'($unsigned(y_i));
          n_d      = n_sat;
          parity_d = 1'b0;
          if (n_sat < NW'(3)) begin
            state_d = S_FINISH;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = AW'(n_sat - NW'(1));
            state_d   = S_LOADJ;
          end
        end
      end
      S_LOADJ: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        i_d       = '0;
        state_d   = S_FETCH;
      end
      S_FETCH: begin
        if (straddle) begin
          state_d = S_MULA;
        end else if (last) begin
          state_d = S_FINISH;
        end else begin
          ram_re = 1'b1;
          i_d    = i_q + NW'(1);
        end
      end
      S_MULA: begin
        state_d = S_MULB;
      end
      S_MULB: begin
        pend_d = 1'b1;
        if (last) begin
          state_d = S_FINISH;
        end else begin
          ram_re  = 1'b1;
          i_d     = i_q + NW'(1);
          state_d = S_FETCH;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          inside_d    = parity_d;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      inside_q    <= 1'b0;
      parity_q    <= 1'b0;
      pend_q      <= 1'b0;
      n_q         <= '0;
      i_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      inside_q    <= inside_d;
      parity_q    <= parity_d;
      pend_q      <= pend_d;
      n_q         <= n_d;
      i_q         <= i_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    px_q <= px_d;
    py_q <= py_d;
    if (state_q == S_LOADJ || state_q == S_FETCH) begin
      prev_x_q <= rd_x;
      prev_y_q <= rd_y;
    end
    if (state_q == S_FETCH) begin
      dxp_q    <= {px_q[CW-1], px_q} - {rd_x[CW-1], rd_x};
      dxj_q    <= {prev_x_q[CW-1], prev_x_q} - {rd_x[CW-1], rd_x};
      dy_q     <= {prev_y_q[CW-1], prev_y_q} - {rd_y[CW-1], rd_y};
      dpy_q    <= {py_q[CW-1], py_q} - {rd_y[CW-1], rd_y};
      dy_pos_q <= (prev_y_q > rd_y);
    end
    if (state_q == S_MULA) begin
      p1_q <= prod;
    end
    if (state_q == S_MULB) begin
      p2_q <= prod;
    end
  end

endmodule

// File: rtl/pip_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_chk: port-level checks for the point-in-polygon test
// Watches both channels over time; bound to the top level below.
// ----------------------------------------------------------------------------
module pip_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic cmd_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic inside_res_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(inside_res_o))
    else $error("result changed or dropped while stalled");

  // a test transfer occupies the block
  a_test_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_i == pip_pkg::CMD_TEST) |=> in_stall_o)
    else $error("block ready right after a test transfer");

  // a vertex write leaves the block ready
  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_i == pip_pkg::CMD_WRITE) |=> !in_stall_o)
    else $error("block busy after a vertex write");

  // a new result comes only out of a running test
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a running test");

endmodule

bind point_in_polygon_test pip_chk u_pip_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .cmd_i        (cmd_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .inside_res_o (inside_res_o)
);
